// ----- src/ldf_pkg.sv -----
// Package for the length-prefixed deframer: item types, status codes and
// register map constants. No dependencies.
`timescale 1ns / 1ps

package ldf_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PAYLOAD  = 2'd0,
    ST_BAD_SYNC = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Register indexes (byte address / 4)
  typedef enum logic {
    REG_SYNC_WORD   = 1'b0,
    REG_MAX_PAYLOAD = 1'b1
  } reg_idx_t;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [15:0] SYNC_WORD_RST   = 16'h0000;
  localparam logic [31:0] MAX_PAYLOAD_RST = 32'd64512;

  typedef struct packed {
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [31:0] frame_length;
    logic        first_of_frame;
    logic        last_of_frame;
    status_t     status;
  } out_item_t;

endpackage

// ----- src/ldf_stream_if.sv -----
// Valid/ready stream interface carrying one request per handshake.
// Payload type is a parameter; normally a struct from ldf_pkg.
`timescale 1ns / 1ps

interface ldf_stream_if #(
  parameter type payload_t = logic [7:0]
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- src/length_prefixed_deframer.sv -----
// Each accepted byte is held in the input register, then any result in the output register.
// Throughput: one byte per cycle unless out_ch stalls, set by the single-pass decision stage.
// A waiting result lets one more byte into the input register, then holds the input.
// Reset (rst_n low, synchronous): pipeline empties, deframer hunts for a header,
// sync_word returns to 0 and max_payload_len to 64512.
`timescale 1ns / 1ps

module length_prefixed_deframer #(
  parameter int unsigned LENGTH_FIELD_BYTES = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ldf_stream_if.sink                       in_ch,
  ldf_stream_if.source                     out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ldf_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ldf_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ldf_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  import ldf_pkg::*;

  localparam int unsigned HDR_BYTES  = 2 + LENGTH_FIELD_BYTES;
  localparam int unsigned LEN_BITS   = 8 * LENGTH_FIELD_BYTES;
  localparam int unsigned SHIFT_BITS = 8 * HDR_BYTES;
  localparam int unsigned CNT_W      = $clog2(HDR_BYTES);
  localparam logic [CNT_W-1:0] LAST_HDR_IDX = CNT_W'(HDR_BYTES - 1);

  // Configuration registers
  logic [15:0] sync_word_r;
  logic [31:0] max_len_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;

  // Input stage
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r, s1_byte_nxt;
  logic       advance;

  // Deframer state
  logic [CNT_W-1:0]      hdr_count_r, hdr_count_nxt;
  logic [SHIFT_BITS-1:0] hdr_shift_r, hdr_shift_nxt;
  logic [31:0]           remaining_r, remaining_nxt;
  logic [31:0]           held_len_r, held_len_nxt;
  logic                  in_payload_r, in_payload_nxt;
  logic                  first_r, first_nxt;

  // Decision stage
  logic [SHIFT_BITS-1:0] new_shift;
  logic [LEN_BITS-1:0]   hdr_len;
  logic [31:0]           hdr_len32;
  logic [15:0]           hdr_sync;
  logic                  res_valid;
  out_item_t             res;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  // APB register access
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_SYNC_WORD:   prdata = {16'h0000, sync_word_r};
      REG_MAX_PAYLOAD: prdata = max_len_r;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= SYNC_WORD_RST;
      max_len_r   <= MAX_PAYLOAD_RST;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_SYNC_WORD) begin
        sync_word_r <= pwdata[15:0];
      end else begin
        max_len_r <= pwdata;
      end
    end
  end

  // Advance the input stage whenever the output register is free or draining
  assign advance     = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~s1_valid_r | advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    if (in_ch.valid && in_ch.ready) begin
      s1_valid_nxt = 1'b1;
      s1_byte_nxt  = in_ch.payload.data_byte;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Header fields as they stand once the current byte is shifted in
  assign new_shift = {hdr_shift_r[SHIFT_BITS-9:0], s1_byte_r};
  assign hdr_len   = new_shift[LEN_BITS-1:0];
  assign hdr_sync  = new_shift[SHIFT_BITS-1 -: 16];
  assign hdr_len32 = 32'(hdr_len);

  // Per-byte decision: pass payload on, or collect and check a header
  always_comb begin
    hdr_count_nxt  = hdr_count_r;
    hdr_shift_nxt  = hdr_shift_r;
    remaining_nxt  = remaining_r;
    held_len_nxt   = held_len_r;
    in_payload_nxt = in_payload_r;
    first_nxt      = first_r;
    res_valid      = 1'b0;
    res            = '{payload_byte: 8'h00, frame_length: 32'h0,
                       first_of_frame: 1'b0, last_of_frame: 1'b0,
                       status: ST_PAYLOAD};
    if (advance) begin
      if (in_payload_r) begin
        res_valid          = 1'b1;
        res.payload_byte   = s1_byte_r;
        res.frame_length   = held_len_r;
        res.first_of_frame = first_r;
        res.last_of_frame  = (remaining_r == 32'd1);
        remaining_nxt      = remaining_r - 32'd1;
        first_nxt          = 1'b0;
        if (remaining_r == 32'd1) begin
          in_payload_nxt = 1'b0;
        end
      end else if (hdr_count_r == LAST_HDR_IDX) begin
        hdr_count_nxt = '0;
        held_len_nxt  = hdr_len32;
        if (hdr_sync != sync_word_r) begin
          res_valid        = 1'b1;
          res.frame_length = hdr_len32;
          res.status       = ST_BAD_SYNC;
        end else if (hdr_len32 > max_len_r) begin
          res_valid        = 1'b1;
          res.frame_length = hdr_len32;
          res.status       = ST_TOO_LONG;
        end else if (hdr_len32 == 32'd0) begin
          res_valid         = 1'b1;
          res.last_of_frame = 1'b1;
          res.status        = ST_EMPTY;
        end else begin
          in_payload_nxt = 1'b1;
          remaining_nxt  = hdr_len32;
          first_nxt      = 1'b1;
        end
      end else begin
        hdr_count_nxt = CNT_W'(hdr_count_r + 1'b1);
        hdr_shift_nxt = new_shift;
      end
    end
  end

  // Output register: drop on handshake, load on a new result
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      hdr_count_r  <= '0;
      in_payload_r <= 1'b0;
      first_r      <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      hdr_count_r  <= hdr_count_nxt;
      in_payload_r <= in_payload_nxt;
      first_r      <= first_nxt;
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    s1_byte_r   <= s1_byte_nxt;
    hdr_shift_r <= hdr_shift_nxt;
    remaining_r <= remaining_nxt;
    held_len_r  <= held_len_nxt;
    out_item_r  <= out_item_nxt;
  end

endmodule

// ----- src/ldf_checker.sv -----
// Port-level checks for length_prefixed_deframer, attached by bind.
// Depends on ldf_pkg for the status codes.
`timescale 1ns / 1ps

module ldf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_first,
  input logic       out_last,
  input logic [1:0] out_status
);

  import ldf_pkg::*;

  // Hold a stalled result's byte and status unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_status))
    else $error("stalled result changed");

  // Empty the output after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // First mark only on payload requests
  a_first_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first |-> out_status == ST_PAYLOAD)
    else $error("first mark on a status result");

  // Status-only results carry no byte, and only an empty frame is marked last
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_PAYLOAD |->
      out_byte == 8'h00 && out_last == (out_status == ST_EMPTY))
    else $error("bad fields on a status result");

endmodule

bind length_prefixed_deframer ldf_checker u_ldf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.payload.payload_byte),
  .out_first  (out_ch.payload.first_of_frame),
  .out_last   (out_ch.payload.last_of_frame),
  .out_status (out_ch.payload.status)
);
